// ----- rtl/core/ifq_pkg.sv -----
// Shared types and codes for the index allocator with a free queue.
package ifq_pkg;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} ifq_op_t;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_LOWERED = 2'd2,
		ST_REJECT  = 2'd3
	} ifq_status_t;

	typedef struct packed {
		ifq_op_t    operation;
		logic [7:0] release_index;
	} ifq_req_t;

	typedef struct packed {
		logic [7:0]  granted_index;
		ifq_status_t status;
		logic [8:0]  high_water;
	} ifq_rsp_t;

endpackage

// ----- rtl/core/index_allocator_free_queue.sv -----
// Top level of the index allocator: high-water mark, free queue control and result register.
//
// Usage: a request word (allocate, or release of release_index) is taken at a clock
// edge where start is high and busy is low. busy is always low, so one request can be
// issued in every cycle. In the cycle after a request is taken, done is high for
// one cycle and rsp carries the result word: the granted index, the status and the
// high-water mark after the request. The receiver cannot stall; a result is gone
// after its cycle. Throughput is one request per cycle; the single read port of the
// queue memory is registered, and its read data feeds the result.
// An allocate takes the oldest queued index if the queue holds one, otherwise the
// mark, which then grows. A release of the index just below the mark lowers the
// mark; any other release below the mark joins the queue. Exhaustion, a release at
// or above the mark, and a release into a full queue return the reject status and
// change nothing. Reset clears the mark and the queue pointers and count; the queue
// memory itself is not cleared, since the count guards every read of it.
module index_allocator_free_queue
	import ifq_pkg::*;
#(
	parameter int INDEX_COUNT = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ifq_req_t req,
	output logic     done,
	output ifq_rsp_t rsp
);

	localparam int MW   = $clog2(INDEX_COUNT + 1);
	localparam int AW   = (INDEX_COUNT > 2) ? $clog2(INDEX_COUNT) : 1;
	localparam int CMPW = (MW > 9) ? MW : 9;

	logic [MW-1:0] mark_q, mark_d;
	logic [MW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;

	logic [CMPW-1:0] mark_w, idx_w, mark_d_w;
	logic            accept;
	logic            q_nonempty, q_full, mark_full;
	logic            push, pop;
	ifq_status_t     status_d;
	logic [7:0]      grant_d;

	logic        done_s1;
	ifq_status_t status_s1;
	logic        from_queue_s1;
	logic [7:0]  grant_s1;
	logic [8:0]  hw_s1;
	logic [7:0]  rd_data;

	assign busy   = 1'b0;
	assign accept = start;

	assign mark_w     = CMPW'(mark_q);
	assign idx_w      = CMPW'(req.release_index);
	assign q_nonempty = (count_q != '0);
	assign q_full     = (count_q == MW'(INDEX_COUNT));
	assign mark_full  = (mark_q == MW'(INDEX_COUNT));

	always_comb begin
		mark_d   = mark_q;
		count_d  = count_q;
		head_d   = head_q;
		tail_d   = tail_q;
		push     = 1'b0;
		pop      = 1'b0;
		grant_d  = 8'd0;
		status_d = ST_REJECT;
		if (req.operation == OP_ALLOC) begin
			if (q_nonempty) begin
				pop      = 1'b1;
				status_d = ST_GRANTED;
			end else if (!mark_full) begin
				grant_d  = mark_w[7:0];
				mark_d   = mark_q + MW'(1);
				status_d = ST_GRANTED;
			end
		end else begin
			if (idx_w >= mark_w) begin
				status_d = ST_REJECT;
			end else if (idx_w + CMPW'(1) == mark_w) begin
				mark_d   = mark_q - MW'(1);
				status_d = ST_LOWERED;
			end else if (!q_full) begin
				push     = 1'b1;
				status_d = ST_QUEUED;
			end
		end
		if (pop) begin
			head_d  = (head_q == AW'(INDEX_COUNT - 1)) ? '0 : head_q + AW'(1);
			count_d = count_q - MW'(1);
		end
		if (push) begin
			tail_d  = (tail_q == AW'(INDEX_COUNT - 1)) ? '0 : tail_q + AW'(1);
			count_d = count_q + MW'(1);
		end
	end

	assign mark_d_w = CMPW'(mark_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				mark_q  <= mark_d;
				count_q <= count_d;
				head_q  <= head_d;
				tail_q  <= tail_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1     <= status_d;
			from_queue_s1 <= pop;
			grant_s1      <= grant_d;
			hw_s1         <= mark_d_w[8:0];
		end
	end

	// The queue entry at the head is read at the accepting edge and lands with the result.
	ifq_queue_ram #(
		.DEPTH(INDEX_COUNT),
		.AW   (AW)
	) u_queue (
		.clk  (clk),
		.we   (accept && push),
		.waddr(tail_q),
		.wdata(req.release_index),
		.re   (accept && pop),
		.raddr(head_q),
		.rdata(rd_data)
	);

	assign done              = done_s1;
	assign rsp.granted_index = from_queue_s1 ? rd_data : grant_s1;
	assign rsp.status        = status_s1;
	assign rsp.high_water    = hw_s1;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted request gave no result");

	a_no_grant_on_other: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_GRANTED |-> rsp.granted_index == 8'd0)
		else $error("nonzero index on a result that is not a grant");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MW'(INDEX_COUNT))
		else $error("queue count above its depth");

	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= MW'(INDEX_COUNT))
		else $error("high-water mark above the index count");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pop |=> count_q == $past(count_q) - MW'(1))
		else $error("queue pop did not lower the count");

endmodule

// ----- rtl/core/ifq_queue_ram.sv -----
// Storage for released indices: one write port and one registered read port.
module ifq_queue_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/sv/tb_index_allocator_free_queue.sv -----
// Self-checking testbench for the index allocator with a free queue.
module tb_index_allocator_free_queue;
	import ifq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IDX     = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOWN_ERRS  = 10;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ifq_req_t req;
	logic     done;
	ifq_rsp_t rsp;

	index_allocator_free_queue #(
		.INDEX_COUNT(NUM_IDX)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the allocator state, advanced once per accepted word.
	logic [8:0] free_mark;
	logic [7:0] free_slots [NUM_IDX];
	logic [7:0] free_head;
	logic [7:0] free_tail;
	logic [8:0] free_fill;

	ifq_rsp_t pending_rsp [$];

	int mismatch_count = 0;
	int n_requests     = 0;
	int n_granted      = 0;
	int n_queued       = 0;
	int n_lowered      = 0;
	int n_rejected     = 0;
	int n_exhausted    = 0;
	int n_queue_full   = 0;
	int n_head_wraps   = 0;
	int cycle_count    = 0;

	function automatic ifq_rsp_t predict_response(input ifq_req_t w);
		ifq_rsp_t r;
		r        = '0;
		r.status = ST_REJECT;
		if (w.operation == OP_ALLOC) begin
			if (free_fill != 9'd0) begin
				r.granted_index = free_slots[free_head];
				r.status        = ST_GRANTED;
				if (free_head == 8'd255)
					n_head_wraps++;
				free_head = free_head + 8'd1;
				free_fill = free_fill - 9'd1;
			end else if (free_mark < 9'(NUM_IDX)) begin
				r.granted_index = free_mark[7:0];
				r.status        = ST_GRANTED;
				free_mark       = free_mark + 9'd1;
			end else begin
				n_exhausted++;
			end
		end else begin
			if ({1'b0, w.release_index} >= free_mark) begin
				r.status = ST_REJECT;
			end else if ({1'b0, w.release_index} + 9'd1 == free_mark) begin
				// The mark drops even if this index still sits in the queue.
				free_mark = free_mark - 9'd1;
				r.status  = ST_LOWERED;
			end else if (free_fill >= 9'(NUM_IDX)) begin
				n_queue_full++;
			end else begin
				free_slots[free_tail] = w.release_index;
				free_tail             = free_tail + 8'd1;
				free_fill             = free_fill + 9'd1;
				r.status              = ST_QUEUED;
			end
		end
		r.high_water = free_mark;
		case (r.status)
			ST_GRANTED: n_granted++;
			ST_QUEUED:  n_queued++;
			ST_LOWERED: n_lowered++;
			default:    n_rejected++;
		endcase
		n_requests++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input ifq_rsp_t want,
			input ifq_rsp_t got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRS)
			$display("%0t: %s: want idx %0d st %0d mark %0d, got idx %0d st %0d mark %0d",
				$realtime, what, want.granted_index, want.status, want.high_water,
				got.granted_index, got.status, got.high_water);
	endtask

	// Words are predicted when taken and checked in order when they come back.
	always @(posedge clk) begin
		ifq_rsp_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_rsp.push_back(predict_response(req));
			if (done) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("result word with nothing outstanding", '0, rsp);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.granted_index !== want.granted_index ||
							rsp.status !== want.status ||
							rsp.high_water !== want.high_water)
						report_mismatch("result word differs", want, rsp);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("index_allocator_free_queue regression: fail");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken, or later after a random idle gap.
	task automatic send_word(input ifq_req_t w, input int idle_pct);
		int gap;
		start <= 1'b1;
		req   <= w;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(15) == 0) ? $urandom_range(24, 5) : $urandom_range(4, 1);
			start <= 1'b0;
			req   <= ifq_req_t'(9'($urandom));
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_alloc(input int idle_pct);
		ifq_req_t w;
		w.operation     = OP_ALLOC;
		w.release_index = 8'($urandom_range(255));
		send_word(w, idle_pct);
	endtask

	task automatic send_release(input logic [7:0] idx, input int idle_pct);
		ifq_req_t w;
		w.operation     = OP_RELEASE;
		w.release_index = idx;
		send_word(w, idle_pct);
	endtask

	// Holds the sender off until every outstanding word is back, then lets the
	// registered result stage settle.
	task automatic settle_outstanding();
		int waited;
		start  <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < 64) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	function automatic ifq_req_t pick_request(input int grow_pct);
		ifq_req_t   w;
		int         k;
		logic [7:0] slot;
		w.operation     = OP_RELEASE;
		w.release_index = 8'($urandom_range(255));
		if ($urandom_range(99) < grow_pct) begin
			w.operation = OP_ALLOC;
		end else if (free_mark != 9'd0) begin
			k = $urandom_range(99);
			if (k < 20) begin
				w.release_index = 8'(free_mark - 9'd1);
			end else if (k < 85) begin
				w.release_index = 8'($urandom_range(int'(free_mark) - 1));
			end else if (k < 93 && free_fill != 9'd0) begin
				// Release an index that is already queued.
				slot            = free_head + 8'($urandom_range(int'(free_fill) - 1));
				w.release_index = free_slots[slot];
			end
		end
		return w;
	endfunction

	task automatic test_basic_sequence();
		send_release(8'd0, 0);
		send_release(8'd255, 0);
		repeat (4) send_alloc(0);
		send_release(8'd3, 0);
		send_release(8'd0, 0);
		send_release(8'd1, 0);
		repeat (3) send_alloc(0);
		send_release(8'd4, 0);
		send_release(8'd200, 0);
		send_release(8'd2, 0);
		send_release(8'd2, 0);
		repeat (2) send_alloc(0);
		// Lower the mark past an index that is still queued: it gets handed out twice.
		send_release(8'd1, 0);
		send_release(8'd3, 0);
		send_release(8'd2, 0);
		send_release(8'd1, 0);
		repeat (2) send_alloc(0);
		settle_outstanding();
	endtask

	task automatic test_exhaustion();
		while (!(free_fill == 9'd0 && free_mark == 9'(NUM_IDX)))
			send_alloc(71);
		repeat (2) send_alloc(71);
		send_release(8'd255, 71);
		send_release(8'd200, 71);
		repeat (3) send_alloc(71);
		settle_outstanding();
	endtask

	task automatic test_queue_full();
		while (free_mark < 9'd2)
			send_alloc(10);
		while (free_fill < 9'(NUM_IDX))
			send_release(8'd0, 10);
		send_release(8'd0, 10);
		while (free_fill != 9'd0)
			send_alloc(10);
		settle_outstanding();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle_pct);
		int grow_pct;
		grow_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			// Swing between growing and shrinking so the mark sweeps its range.
			if (i % 48 == 0)
				grow_pct = $urandom_range(1) ? $urandom_range(90, 70) : $urandom_range(35, 15);
			send_word(pick_request(grow_pct), idle_pct);
		end
		settle_outstanding();
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		free_mark = '0;
		free_head = '0;
		free_tail = '0;
		free_fill = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_sequence();
		test_exhaustion();
		test_queue_full();
		// The receiver has no way to stall, so only the sender idles.
		test_random_traffic(220, 0);
		test_random_traffic(200, 71);
		test_random_traffic(230, 10);

		$display("%0d words: %0d grants, %0d queued, %0d mark releases, %0d rejects",
			n_requests, n_granted, n_queued, n_lowered, n_rejected);
		$display("exhausted %0d times, full queue %0d times, queue head wrapped %0d times",
			n_exhausted, n_queue_full, n_head_wraps);
		if (pending_rsp.size() != 0)
			$display("%0d result words never arrived", pending_rsp.size());
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("index_allocator_free_queue regression: pass");
		else
			$display("index_allocator_free_queue regression: fail");
		$finish;
	end

endmodule
